// ----- src/base32_text_decoder_defines.svh -----
// Assertion macros shared by the Base32 text decoder RTL.
`ifndef BASE32_TEXT_DECODER_DEFINES_SVH
`define BASE32_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define B32D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define B32D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/b32d_pkg.sv -----
// Types, character constants and the symbol decode function of the Base32 decoder.
package b32d_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [4:0]  sym_val_t;
  typedef logic [11:0] bit_buf_t;
  typedef logic [2:0]  bit_cnt_t;

  localparam char_t CHR_UA    = 8'h41;  // 'A'
  localparam char_t CHR_UZ    = 8'h5A;  // 'Z'
  localparam char_t CHR_LA    = 8'h61;  // 'a'
  localparam char_t CHR_LZ    = 8'h7A;  // 'z'
  localparam char_t CHR_D2    = 8'h32;  // '2'
  localparam char_t CHR_D7    = 8'h37;  // '7'
  localparam char_t CHR_PAD   = 8'h3D;  // '='
  localparam char_t CHR_SPACE = 8'h20;
  localparam char_t CHR_TAB   = 8'h09;
  localparam char_t CHR_CR    = 8'h0D;
  localparam char_t CASE_OFFSET    = CHR_LA - CHR_UA;
  localparam char_t SYM_DIGIT_BASE = 8'd26;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned SYM_BITS  = 5;

  typedef enum logic [1:0] {
    SK_SYMBOL,
    SK_SKIP,
    SK_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t kind;
    sym_val_t  value;
  } sym_t;

  // Classifies one character code and gives its five-bit symbol value.
  function automatic sym_t b32d_classify(input char_t ch);
    sym_t  r;
    char_t up;
    r.kind  = SK_BAD;
    r.value = '0;
    up      = ch;
    if (ch inside {[CHR_LA:CHR_LZ]}) begin
      up = ch - CASE_OFFSET;
    end
    case (up) inside
      [CHR_UA:CHR_UZ]: begin
        r.kind  = SK_SYMBOL;
        r.value = sym_val_t'(up - CHR_UA);
      end
      [CHR_D2:CHR_D7]: begin
        r.kind  = SK_SYMBOL;
        r.value = sym_val_t'(up - CHR_D2 + SYM_DIGIT_BASE);
      end
      CHR_PAD, CHR_SPACE, [CHR_TAB:CHR_CR]: begin
        r.kind = SK_SKIP;
      end
      default: begin
        r.kind = SK_BAD;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- src/b32d_in_if.sv -----
// Character input channel of the Base32 decoder.
interface b32d_in_if;
  logic              valid;
  logic              ready;
  b32d_pkg::char_t   char_in;
  logic              last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

// ----- src/b32d_out_if.sv -----
// Result channel of the Base32 decoder.
interface b32d_out_if;
  logic              valid;
  logic              ready;
  b32d_pkg::char_t   data_byte;
  logic              byte_valid;
  logic              invalid_char;
  logic              end_of_string;

  modport source (output valid, output data_byte, output byte_valid,
                  output invalid_char, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input invalid_char, input end_of_string, output ready);
endinterface

// ----- src/base32_text_decoder.sv -----
// A character beat is held in the input register, then its result beat in the output register.
// Throughput: one character per cycle while the sink keeps up, set by the input
// register feeding the output register through one pass of map, shift and compare logic.
// Reset: synchronous, active-low rst_n empties both registers and clears the
// bit buffer, the pending bit count and the error mark.
`include "base32_text_decoder_defines.svh"

module base32_text_decoder (
  input  logic clk,
  input  logic rst_n,
  b32d_in_if.sink    in_bus,
  b32d_out_if.source out_bus
);
  import b32d_pkg::*;

  // Input register: holds one accepted character beat.
  logic     s1_valid_r, s1_valid_nxt;
  char_t    s1_char_r;
  logic     s1_last_r;

  // Decoder state carried from one character to the next.
  bit_buf_t buf_r, buf_nxt;
  bit_cnt_t pend_r, pend_nxt;
  logic     err_r, err_nxt;

  // Output register: one result beat waiting for the sink.
  logic     out_valid_r, out_valid_nxt;
  char_t    out_byte_r;
  logic     out_bv_r, out_bad_r, out_eos_r;

  logic     out_free, s1_fire, in_fire;
  sym_t     cls;
  logic     take_sym, is_bad, have_byte, res_valid;
  bit_buf_t buf_shift;
  logic [3:0] pend_sum;
  bit_cnt_t pend_after;
  char_t    byte_val;

  // The output register can take a new result when it is empty or being drained.
  // The input register moves whenever the output register can take its result,
  // so a character is accepted every cycle while the sink keeps up.
  assign out_free     = !out_valid_r || out_bus.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Per-character decode. Once an invalid character has been seen, the rest of
  // the string is ignored until its last character.
  always_comb begin
    cls        = b32d_classify(s1_char_r);
    take_sym   = !err_r && (cls.kind == SK_SYMBOL);
    is_bad     = !err_r && (cls.kind == SK_BAD);
    buf_shift  = {buf_r[$bits(bit_buf_t)-SYM_BITS-1:0], cls.value};
    pend_sum   = {1'b0, pend_r} + 4'(SYM_BITS);
    have_byte  = take_sym && (pend_sum >= 4'(BYTE_BITS));
    pend_after = have_byte ? bit_cnt_t'(pend_sum - 4'(BYTE_BITS)) : bit_cnt_t'(pend_sum);
    byte_val   = char_t'(buf_shift >> pend_after);
    res_valid  = have_byte || is_bad || s1_last_r;
  end

  // Next state. The last character of a string returns everything to zero so
  // leftover bits and the error mark never reach the next string.
  always_comb begin
    buf_nxt  = buf_r;
    pend_nxt = pend_r;
    err_nxt  = err_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        buf_nxt  = '0;
        pend_nxt = '0;
        err_nxt  = 1'b0;
      end else begin
        if (take_sym) begin
          buf_nxt  = buf_shift;
          pend_nxt = pend_after;
        end
        if (is_bad) begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_bus.ready) begin
      s1_valid_nxt = in_bus.valid;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = res_valid;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      buf_r       <= '0;
      pend_r      <= '0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      buf_r       <= buf_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers load on their handshakes and need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_bus.char_in;
      s1_last_r <= in_bus.last_char;
    end
    if (s1_fire) begin
      out_byte_r <= have_byte ? byte_val : '0;
      out_bv_r   <= have_byte;
      out_bad_r  <= is_bad;
      out_eos_r  <= s1_last_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.data_byte     = out_byte_r;
  assign out_bus.byte_valid    = out_bv_r;
  assign out_bus.invalid_char  = out_bad_r;
  assign out_bus.end_of_string = out_eos_r;

  // Checks on the decoder's own bookkeeping and on the result handshake.
  `B32D_ASSERT_NEXT(a_out_hold, out_valid_r && !out_bus.ready,
                    out_valid_r && $stable(out_byte_r) && $stable(out_eos_r),
                    "result beat changed while the sink stalled")
  `B32D_ASSERT_NEXT(a_eos_clears, s1_fire && s1_last_r,
                    buf_r == '0 && pend_r == '0 && !err_r, "state not cleared after end of string")
  `B32D_ASSERT_NOW(a_err_no_byte, s1_fire && err_r, !have_byte && !is_bad,
                   "decoding continued after an invalid character")
  `B32D_ASSERT_NOW(a_byte_xor_bad, out_valid_r, !(out_bv_r && out_bad_r),
                   "result beat flags both a byte and an invalid character")

endmodule

// ----- dv/b32d_decode_checker.sv -----
// Checker for the Base32 text decoder: predicts each result beat and compares it.
`timescale 1ns / 100ps

module b32d_decode_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  b32d_pkg::char_t in_char,
  input  logic            in_last,
  input  logic            out_valid,
  input  logic            out_ready,
  input  b32d_pkg::char_t out_data_byte,
  input  logic            out_byte_valid,
  input  logic            out_invalid_char,
  input  logic            out_end_of_string,
  output int              mismatches,
  output int              results_owed,
  output int              bytes_seen,
  output int              errors_seen,
  output int              ends_seen
);
  import b32d_pkg::*;

  typedef struct packed {
    char_t data_byte;
    logic  byte_valid;
    logic  invalid_char;
    logic  end_of_string;
  } dec_result_t;

  // Decoder state as the predictor sees it.
  bit_buf_t    sym_bits;
  logic [2:0]  bits_held;
  logic        string_failed;
  dec_result_t owed_results[$];

  // Applies one character to the predicted state; returns 1 when it gives a result.
  function automatic bit decode_char(input char_t ch, input logic last,
                                     output dec_result_t res);
    sym_kind_t  kind;
    sym_val_t   val;
    char_t      up;
    logic [3:0] cnt;
    res  = '0;
    val  = '0;
    up   = (ch >= CHR_LA && ch <= CHR_LZ) ? char_t'(ch - CASE_OFFSET) : ch;
    if (up >= CHR_UA && up <= CHR_UZ) begin
      kind = SK_SYMBOL;
      val  = sym_val_t'(up - CHR_UA);
    end else if (up >= CHR_D2 && up <= CHR_D7) begin
      kind = SK_SYMBOL;
      val  = sym_val_t'(up - CHR_D2 + SYM_DIGIT_BASE);
    end else if (ch == CHR_PAD || ch == CHR_SPACE || (ch >= CHR_TAB && ch <= CHR_CR)) begin
      kind = SK_SKIP;
    end else begin
      kind = SK_BAD;
    end
    if (!string_failed && kind == SK_BAD) begin
      res.invalid_char = 1'b1;
      string_failed    = 1'b1;
    end else if (!string_failed && kind == SK_SYMBOL) begin
      sym_bits = {sym_bits[6:0], val};
      cnt      = {1'b0, bits_held} + 4'd5;
      if (cnt >= 4'd8) begin
        cnt            = cnt - 4'd8;
        res.data_byte  = char_t'(sym_bits >> cnt);
        res.byte_valid = 1'b1;
      end
      bits_held = cnt[2:0];
    end
    res.end_of_string = last;
    if (last) begin
      sym_bits      = '0;
      bits_held     = '0;
      string_failed = 1'b0;
    end
    return res.byte_valid || res.invalid_char || last;
  endfunction

  always @(posedge clk) begin
    dec_result_t want;
    dec_result_t got;
    if (!rst_n) begin
      sym_bits      = '0;
      bits_held     = '0;
      string_failed = 1'b0;
      owed_results.delete();
      mismatches    = 0;
      bytes_seen    = 0;
      errors_seen   = 0;
      ends_seen     = 0;
    end else begin
      // A result beat can never stem from a character taken at this same edge.
      if (out_valid && out_ready) begin
        got = '{out_data_byte, out_byte_valid, out_invalid_char, out_end_of_string};
        bytes_seen  += got.byte_valid;
        errors_seen += got.invalid_char;
        ends_seen   += got.end_of_string;
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, actual %p", $time, got);
        end else begin
          want = owed_results.pop_front();
          if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
              got.invalid_char !== want.invalid_char ||
              got.end_of_string !== want.end_of_string) begin
            mismatches++;
            $display("%0t: result beat differs, expected %p, actual %p", $time, want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_char(in_char, in_last, want)) owed_results = {owed_results, want};
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ----- dv/tb.sv -----
// Top of the Base32 text decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import b32d_pkg::*;

  // Generous ceiling: every character paying the longest sender gap and every
  // result the longest receiver stall, then taken about four times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 2000;

  typedef enum int {TXT_CLEAN, TXT_BROKEN, TXT_NOISE} text_kind_t;

  logic clk;
  logic rst_n;

  b32d_in_if  in_ch ();
  b32d_out_if out_ch ();

  base32_text_decoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch.sink),
    .out_bus (out_ch.source)
  );

  int mismatches;
  int results_owed;
  int bytes_seen;
  int errors_seen;
  int ends_seen;

  // The checker sits beside the block and sees both channels as a passive observer.
  b32d_decode_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_char           (in_ch.char_in),
    .in_last           (in_ch.last_char),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_data_byte     (out_ch.data_byte),
    .out_byte_valid    (out_ch.byte_valid),
    .out_invalid_char  (out_ch.invalid_char),
    .out_end_of_string (out_ch.end_of_string),
    .mismatches        (mismatches),
    .results_owed      (results_owed),
    .bytes_seen        (bytes_seen),
    .errors_seen       (errors_seen),
    .ends_seen         (ends_seen)
  );

  int cycles = 0;
  int chars_sent;
  int strings_sent;
  bit steady;  // When set, neither side inserts idle cycles.

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog. A run that hangs is a failed run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Most gaps are zero, many are short, and a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // The result side stalls at random. Ready changes only on the falling edge,
  // and is assigned once per edge.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = steady ? 0 : pick_gap();
      end
    end
  end

  // Offers one character beat and returns on the falling edge after it was taken.
  // Valid stays high straight into the next beat when no gap is drawn.
  task automatic send_beat(input char_t ch, input logic last);
    int g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.char_in   <= ch;
    in_ch.last_char <= last;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
    if (last) strings_sent++;
    @(negedge clk);
  endtask

  // A character from well-formed text: a symbol of either case, or a skipped code.
  function automatic char_t text_char();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 40) return char_t'(CHR_UA + $urandom_range(0, 25));
    if (r < 65) return char_t'(CHR_LA + $urandom_range(0, 25));
    if (r < 85) return char_t'(CHR_D2 + $urandom_range(0, 5));
    s = $urandom_range(0, 6);
    if (s < 5) return char_t'(CHR_TAB + s);
    return (s == 5) ? CHR_SPACE : CHR_PAD;
  endfunction

  // A code that is neither a symbol nor skipped, often close to a valid range.
  function automatic char_t bad_char();
    case ($urandom_range(0, 7))
      0: return char_t'($urandom_range(0, 8));
      1: return char_t'($urandom_range(14, 31));
      2: return char_t'(CHR_D2 - 1);
      3: return char_t'(CHR_D7 + 1);
      4: return char_t'(CHR_UA - 1);
      5: return char_t'(CHR_LZ + 1);
      default: return char_t'($urandom_range(128, 255));
    endcase
  endfunction

  // One whole string. Long strings are rare, so runs of bytes still come often.
  task automatic send_text(input text_kind_t kind);
    int len;
    int bad_at;
    char_t ch;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
    bad_at = (kind == TXT_BROKEN) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (kind == TXT_NOISE) ch = char_t'($urandom_range(0, 255));
      else if (i == bad_at)  ch = bad_char();
      else                   ch = text_char();
      send_beat(ch, i == len - 1);
    end
  endtask

  task automatic drain_results();
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin
    int r;
    int target;
    chars_sent      = 0;
    strings_sent    = 0;
    steady          = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_in   = '0;
    in_ch.last_char = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings. The first mixes both cases, the digit extremes and tab, carriage
    // return and space between symbols, so bytes straddle the skipped codes.
    send_beat(CHR_LA, 1'b0);
    send_beat(CHR_UZ, 1'b0);
    send_beat(CHR_TAB, 1'b0);
    send_beat(CHR_D2, 1'b0);
    send_beat(CHR_D7, 1'b0);
    send_beat(CHR_CR, 1'b0);
    send_beat(CHR_SPACE, 1'b0);
    send_beat(CHR_LZ, 1'b0);
    send_beat(CHR_UA, 1'b1);
    // A padding character alone as the whole string only closes it.
    send_beat(CHR_PAD, 1'b1);
    // An invalid code mid-string, then the rest dropped, even a second bad code.
    send_beat(char_t'(CHR_UA + 1), 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(char_t'(CHR_UA + 2), 1'b0);
    send_beat(8'hFF, 1'b1);
    // Invalid codes as the last character, mostly at the edges of the valid ranges.
    send_beat(char_t'(CHR_D2 - 1), 1'b1);
    send_beat(char_t'(CHR_UA + 16), 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(char_t'(CHR_UA - 1), 1'b1);
    send_beat(char_t'(CHR_LZ + 1), 1'b1);
    send_beat(char_t'(CHR_CR + 1), 1'b1);
    // A lone symbol ends its string without completing a byte.
    send_beat(CHR_D7, 1'b1);

    // Random strings: mostly well-formed text, the rest broken text and noise.
    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) begin
      if (strings_sent == 60 || strings_sent == 180) begin
        in_ch.valid <= 1'b0;
        drain_results();
      end
      steady = (strings_sent >= 100 && strings_sent < 130);
      r = $urandom_range(0, 99);
      if (r < 80)      send_text(TXT_CLEAN);
      else if (r < 92) send_text(TXT_BROKEN);
      else             send_text(TXT_NOISE);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in %0d strings, with clean, broken and noisy text.",
             chars_sent, strings_sent);
    $display("Checked %0d decoded bytes, %0d invalid-character beats, %0d string ends.",
             bytes_seen, errors_seen, ends_seen);
    if (mismatches == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
